FILE: hw/rtl/ra2d_pkg.sv
package ra2d_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned AngleWidth    = 16;
  localparam int unsigned CordicSteps   = 28;
  // datapath width: normalized magnitude stays below 2^59 after growth, plus sign
  localparam int unsigned DpWidth       = 60;
  localparam int unsigned ZWidth        = 34;
  localparam int unsigned NormBits      = 56;

  localparam logic signed [ZWidth-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [ZWidth:0]   PiQ30     = 35'sd3373259426;
  localparam logic signed [ZWidth:0]   TwoPiQ30  = 35'sd6746518852;
  localparam logic [AngleWidth-1:0]    AngleMax  = 16'd51472;

  function automatic logic signed [ZWidth-1:0] atan_q30(input int unsigned idx);
    logic signed [ZWidth-1:0] r;
    r = '0;
    case (idx)
      0:  r = 34'sh3243F6A8;
      1:  r = 34'sh1DAC6705;
      2:  r = 34'sh0FADBAFC;
      3:  r = 34'sh07F56EA6;
      4:  r = 34'sh03FEAB76;
      5:  r = 34'sh01FFD55B;
      6:  r = 34'sh00FFFAAA;
      7:  r = 34'sh007FFF55;
      8:  r = 34'sh003FFFEA;
      9:  r = 34'sh001FFFFD;
      10: r = 34'sh000FFFFF;
      11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF;
      13: r = 34'sh0001FFFF;
      14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF;
      16: r = 34'sh00003FFF;
      17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF;
      19: r = 34'sh000007FF;
      20: r = 34'sh000003FF;
      21: r = 34'sh000001FF;
      22: r = 34'sh000000FF;
      23: r = 34'sh0000007F;
      24: r = 34'sh0000003F;
      25: r = 34'sh0000001F;
      26: r = 34'sh0000000F;
      27: r = 34'sh00000008;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/relative_angle_2d_top.sv
// Channel | Dir | tdata fields (low bit up)                          | tuser
// s_axis  | in  | origin_x, origin_y, first_x, first_y, second_x,   | -
//         |     | second_y (COORD_WIDTH each)                        |
// m_axis  | out | angle[15:0]                                        | degenerate
//
// One transaction per cycle sustained while m_axis is not stalled. Stages:
// difference, pre-rotation, normalize, 28 CORDIC micro-rotations, direction
// difference and magnitude, then the angle fold/round stage. Every stage
// carries a valid bit and all stages advance together, so a stall on m_axis
// freezes the whole pipe and nothing is lost or repeated. s_axis_tready drops
// whenever a result is held on m_axis. Reset clears valid bits only.
module relative_angle_2d_top import ra2d_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // origin_x, origin_y, first_x, first_y, second_x, second_y, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // angle
  output logic [AngleWidth-1:0]    m_axis_tdata,
  // degenerate
  output logic                     m_axis_tuser
);

  localparam int unsigned Cw      = COORD_WIDTH;
  localparam int unsigned Latency = CordicSteps + 5;

  logic [Latency-1:0] vld_q, vld_d;
  logic [Latency-1:0] dg_q;
  logic adv;

  // advance whenever the output slot is empty or being taken
  assign adv           = !vld_q[Latency-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Latency-1];

  logic signed [Cw-1:0] ox, oy, p1x, p1y, p2x, p2y;
  assign ox  = s_axis_tdata[0*Cw +: Cw];
  assign oy  = s_axis_tdata[1*Cw +: Cw];
  assign p1x = s_axis_tdata[2*Cw +: Cw];
  assign p1y = s_axis_tdata[3*Cw +: Cw];
  assign p2x = s_axis_tdata[4*Cw +: Cw];
  assign p2y = s_axis_tdata[5*Cw +: Cw];

  // stage A: difference vectors
  logic signed [Cw:0] ax_q, ay_q, bx_q, by_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= {p1x[Cw-1], p1x} - {ox[Cw-1], ox};
      ay_q <= {p1y[Cw-1], p1y} - {oy[Cw-1], oy};
      bx_q <= {p2x[Cw-1], p2x} - {ox[Cw-1], ox};
      by_q <= {p2y[Cw-1], p2y} - {oy[Cw-1], oy};
    end
  end

  logic signed [ZWidth-1:0] da, db;
  ra2d_cordic #(.CoordWidth(Cw)) u_cordic_a (
    .clk_i, .rst_ni, .adv_i(adv), .x_i(ax_q), .y_i(ay_q), .dir_o(da)
  );
  ra2d_cordic #(.CoordWidth(Cw)) u_cordic_b (
    .clk_i, .rst_ni, .adv_i(adv), .x_i(bx_q), .y_i(by_q), .dir_o(db)
  );

  logic signed [ZWidth:0] dd, ad_q, fd;
  logic [ZWidth:0] rnd;
  logic [AngleWidth-1:0] ang_d, ang_q;
  logic dg_in;

  // difference stage: subtract the two directions and take the magnitude
  always_comb begin
    dd = {da[ZWidth-1], da} - {db[ZWidth-1], db};
    dg_in = ((ax_q == 0) && (ay_q == 0)) || ((bx_q == 0) && (by_q == 0));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ad_q <= dd[ZWidth] ? -dd : dd;
    end
  end

  // final stage: fold into [0, pi], round to Q2.14, saturate
  always_comb begin
    fd = (ad_q > PiQ30) ? (TwoPiQ30 - ad_q) : ad_q;
    if (fd < 0) fd = '0;
    rnd = ($unsigned(fd) + (ZWidth+1)'(32768)) >> 16;
    ang_d = (rnd > (ZWidth+1)'(AngleMax)) ? AngleMax : rnd[AngleWidth-1:0];
    if (dg_q[Latency-2]) ang_d = '0;
  end

  always_comb begin
    vld_d = {vld_q[Latency-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // degenerate flag rides alongside; bit 1 picks up the stage-A result
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dg_q[0] <= 1'b0;
      dg_q[1] <= dg_in;
      dg_q[Latency-1:2] <= dg_q[Latency-2:1];
      ang_q <= ang_d;
    end
  end

  assign m_axis_tdata = ang_q;
  assign m_axis_tuser = dg_q[Latency-1];

  logic unused_dg;
  assign unused_dg = dg_q[0];

  // a held result must stay put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // degenerate results report zero angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero angle");
  // angle never exceeds pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= AngleMax)
    else $error("angle above pi");
  // input is refused only with a full, blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("tready low without backpressure");

endmodule

FILE: hw/rtl/ra2d_cordic.sv
module ra2d_cordic import ra2d_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic signed [CoordWidth:0] x_i,
  input  logic signed [CoordWidth:0] y_i,
  output logic signed [ZWidth-1:0] dir_o
);

  localparam int unsigned NStages = CordicSteps + 1;
  localparam int unsigned LzWidth = $clog2(NormBits + 1);

  // stage 0: quadrant pre-rotation
  logic signed [CoordWidth+1:0] px_d, py_d;
  logic signed [CoordWidth+1:0] px_q, py_q;
  logic signed [ZWidth-1:0]     pb_d, pb_q;

  always_comb begin
    px_d = {x_i[CoordWidth], x_i};
    py_d = {y_i[CoordWidth], y_i};
    pb_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        px_d = {y_i[CoordWidth], y_i};
        py_d = -{x_i[CoordWidth], x_i};
        pb_d = HalfPiQ30;
      end else begin
        px_d = -{y_i[CoordWidth], y_i};
        py_d = {x_i[CoordWidth], x_i};
        pb_d = -HalfPiQ30;
      end
    end
  end

  // stage 1: normalize so max(|x|,|y|) lands in [2^56, 2^57)
  logic [CoordWidth+1:0] ax, ay, mx;
  logic [LzWidth-1:0]    sh;
  logic signed [DpWidth-1:0] nx_d, ny_d;
  logic signed [DpWidth-1:0] xs_q [NStages];
  logic signed [DpWidth-1:0] ys_q [NStages];
  logic signed [ZWidth-1:0]  zs_q [NStages];

  always_comb begin
    ax = px_q[CoordWidth+1] ? (~px_q + 1'b1) : px_q;
    ay = py_q[CoordWidth+1] ? (~py_q + 1'b1) : py_q;
    mx = (ax > ay) ? ax : ay;
    sh = LzWidth'(NormBits);
    for (int b = 0; b <= CoordWidth + 1; b++) begin
      if (mx[b]) sh = LzWidth'(NormBits - b);
    end
    nx_d = DpWidth'(px_q) <<< sh;
    ny_d = DpWidth'(py_q) <<< sh;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pb_q <= pb_d;
      xs_q[0] <= nx_d;
      ys_q[0] <= ny_d;
      zs_q[0] <= pb_q;
    end
  end

  // one CORDIC micro-rotation per register stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [DpWidth-1:0] xsh, ysh;
    assign xsh = xs_q[i] >>> i;
    assign ysh = ys_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (ys_q[i] > 0) begin
          xs_q[i+1] <= xs_q[i] + ysh;
          ys_q[i+1] <= ys_q[i] - xsh;
          zs_q[i+1] <= zs_q[i] + atan_q30(i);
        end else begin
          xs_q[i+1] <= xs_q[i] - ysh;
          ys_q[i+1] <= ys_q[i] + xsh;
          zs_q[i+1] <= zs_q[i] - atan_q30(i);
        end
      end
    end
  end

  assign dir_o = zs_q[NStages-1];

  logic unused;
  assign unused = ^{rst_ni, xs_q[NStages-1], ys_q[NStages-1]};

endmodule
